/* hw/rtl/sha1md_pkg.sv */
package sha1md_pkg;

	localparam int WORDS      = 5;
	localparam int RING_DEPTH = 16;
	localparam int QDEPTH     = 4;
	localparam int QAW        = $clog2(QDEPTH);

	localparam logic [5:0] BLK_LAST   = 6'd63;
	localparam logic [5:0] LEN_START  = 6'd56;
	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [6:0] SCHED_FROM = 7'd16;
	localparam logic [2:0] WORD_LAST  = 3'd4;
	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [63:0] BYTE_BITS = 64'd8;

	typedef logic [31:0] word_t;

	localparam word_t IV [WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam word_t KTAB [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} core_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_wr_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_rd_t;

	function automatic logic [1:0] round_phase(input logic [6:0] rnd);
		logic [1:0] ph;
		if (rnd < 7'd20)
			ph = 2'd0;
		else if (rnd < 7'd40)
			ph = 2'd1;
		else if (rnd < 7'd60)
			ph = 2'd2;
		else
			ph = 2'd3;
		return ph;
	endfunction

	function automatic word_t round_f(input logic [1:0] ph, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		unique case (ph)
			2'd0: f = (b & c) | (~b & d);
			2'd2: f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

/* hw/rtl/sha1md_in_if.sv */
interface sha1md_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] message_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, message_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, message_byte, byte_present, end_of_message, output ready);
endinterface

/* hw/rtl/sha1md_out_if.sv */
interface sha1md_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hw/rtl/sha1md_front.sv */
module sha1md_front
	import sha1md_pkg::*;
(
	sha1md_in_if.sink msg,
	input  logic      q_full,
	output q_wr_t     q_wr
);

	assign msg.ready = !q_full;

	// drop items that carry neither a byte nor the end mark
	always_comb begin
		q_wr.valid       = msg.valid && !q_full && (msg.byte_present || msg.end_of_message);
		q_wr.cmd.data    = msg.message_byte;
		q_wr.cmd.present = msg.byte_present;
		q_wr.cmd.last    = msg.end_of_message;
	end

endmodule

/* hw/rtl/sha1md_queue.sv */
module sha1md_queue
	import sha1md_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t wr,
	input  logic  pop,
	output logic  full,
	output q_rd_t rd
);

	cmd_t           mem [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QAW:0]   cnt_q;

	assign full     = cnt_q == QDEPTH[QAW:0];
	assign rd.valid = cnt_q != '0;
	assign rd.cmd   = mem[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr.valid)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			if (wr.valid && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr.valid && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.valid)
			mem[wptr_q] <= wr.cmd;
	end

endmodule

/* hw/rtl/sha1md_core.sv */
module sha1md_core
	import sha1md_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  q_rd_t rd,
	output logic pop,
	sha1md_out_if.source digest
);

	core_state_t state_q, state_d;

	logic [5:0]  cnt_q;
	logic [23:0] acc_q;
	word_t       sr_q [RING_DEPTH];
	word_t       rw_q [WORDS];
	word_t       chain_q [WORDS];
	logic [63:0] len_q;
	logic [6:0]  rnd_q;
	logic        pad_q;
	logic        mark_q;
	logic        lenph_q;
	logic [2:0]  oidx_q;
	logic        dvld_q;
	word_t       dout_q;
	logic [2:0]  didx_q;
	logic        dlast_q;

	logic        push_en;
	logic [7:0]  push_b;
	logic        ld_out;
	logic        len_now;
	logic [2:0]  lsh;
	logic [7:0]  len_b;
	logic [7:0]  pad_b;
	logic [1:0]  phase;
	word_t       wt;
	word_t       tmp;

	assign len_now = !mark_q && (lenph_q || cnt_q == LEN_START);
	assign lsh     = 3'd7 - cnt_q[2:0];
	assign len_b   = len_q[{lsh, 3'b000} +: 8];
	assign pad_b   = mark_q ? PAD_MARK : (len_now ? len_b : 8'h00);

	assign phase = round_phase(rnd_q);
	assign wt    = (rnd_q < SCHED_FROM) ? sr_q[0]
		: rotl(sr_q[13] ^ sr_q[8] ^ sr_q[2] ^ sr_q[0], 1);
	assign tmp   = rotl(rw_q[0], 5) + round_f(phase, rw_q[1], rw_q[2], rw_q[3])
		+ rw_q[4] + KTAB[phase] + wt;

	assign digest.valid       = dvld_q;
	assign digest.digest_word = dout_q;
	assign digest.word_index  = didx_q;
	assign digest.last_word   = dlast_q;

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		push_en = 1'b0;
		push_b  = rd.cmd.data;
		ld_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (rd.valid) begin
					pop     = 1'b1;
					push_en = rd.cmd.present;
					if (rd.cmd.present && cnt_q == BLK_LAST)
						state_d = ST_ROUND;
					else if (rd.cmd.last)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				push_en = 1'b1;
				push_b  = pad_b;
				if (cnt_q == BLK_LAST)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == ROUND_LAST)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (pad_q && lenph_q)
					state_d = ST_OUT;
				else if (pad_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_OUT: begin
				if (!dvld_q || digest.ready) begin
					ld_out = 1'b1;
					if (oidx_q == WORD_LAST)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			len_q   <= '0;
			rnd_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenph_q <= 1'b0;
			oidx_q  <= '0;
			dvld_q  <= 1'b0;
			for (int i = 0; i < WORDS; i++)
				chain_q[i] <= IV[i];
		end else begin
			if (push_en)
				cnt_q <= cnt_q + 1'b1;
			if (pop && rd.cmd.present)
				len_q <= len_q + BYTE_BITS;
			if (pop && rd.cmd.last) begin
				pad_q  <= 1'b1;
				mark_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				mark_q <= 1'b0;
				if (len_now)
					lenph_q <= 1'b1;
			end
			if (state_q == ST_ROUND)
				rnd_q <= (rnd_q == ROUND_LAST) ? '0 : rnd_q + 1'b1;
			if (state_q == ST_ADD) begin
				for (int i = 0; i < WORDS; i++)
					chain_q[i] <= chain_q[i] + rw_q[i];
			end
			// last digest word loaded: restart for the next message
			if (ld_out) begin
				if (oidx_q == WORD_LAST) begin
					oidx_q  <= '0;
					len_q   <= '0;
					pad_q   <= 1'b0;
					lenph_q <= 1'b0;
					for (int i = 0; i < WORDS; i++)
						chain_q[i] <= IV[i];
				end else begin
					oidx_q <= oidx_q + 1'b1;
				end
			end
			if (ld_out)
				dvld_q <= 1'b1;
			else if (digest.ready)
				dvld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			acc_q <= {acc_q[15:0], push_b};
			if (cnt_q[1:0] == 2'd3) begin
				for (int i = 0; i < RING_DEPTH - 1; i++)
					sr_q[i] <= sr_q[i + 1];
				sr_q[RING_DEPTH - 1] <= {acc_q, push_b};
			end
			if (cnt_q == BLK_LAST) begin
				for (int i = 0; i < WORDS; i++)
					rw_q[i] <= chain_q[i];
			end
		end
		if (state_q == ST_ROUND) begin
			rw_q[0] <= tmp;
			rw_q[1] <= rw_q[0];
			rw_q[2] <= rotl(rw_q[1], 30);
			rw_q[3] <= rw_q[2];
			rw_q[4] <= rw_q[3];
			for (int i = 0; i < RING_DEPTH - 1; i++)
				sr_q[i] <= sr_q[i + 1];
			sr_q[RING_DEPTH - 1] <= wt;
		end
		if (ld_out) begin
			dout_q  <= chain_q[oidx_q];
			didx_q  <= oidx_q;
			dlast_q <= oidx_q == WORD_LAST;
		end
	end

endmodule

/* hw/rtl/sha1_message_digest.sv */
// Each byte item is taken into a four-entry queue and packed by the core while it is idle.
// The 64th byte of a block starts the round steps of a compression, then its add step.
// An end-of-message item pads one byte per cycle, then runs one or two compressions,
// then hands out five digest words, one per cycle while the receiver is ready.
// The single round unit and the one-byte-per-cycle packer set the pace of the block.
// Reset (arst_n low) loads the initial chaining value, clears counters, queue and output.
module sha1_message_digest
	import sha1md_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	sha1md_in_if.sink      msg,
	sha1md_out_if.source   digest
);

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;

	sha1md_front u_front (
		.msg    (msg),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	sha1md_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.rd     (q_rd)
	);

	sha1md_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (q_rd),
		.pop    (q_pop),
		.digest (digest)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.valid |-> !q_full)
		else $error("queue written while full");

	a_no_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_rd.valid)
		else $error("queue popped while empty");

	a_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.ready && !digest.last_word
		|=> digest.valid && digest.word_index == $past(digest.word_index) + 3'd1)
		else $error("digest words not in sequence");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid |-> (digest.last_word == (digest.word_index == WORD_LAST)))
		else $error("last word flag does not match index");

endmodule

/* tb/sv/sha1_message_digest_checker.sv */
module sha1_message_digest_checker
	import sha1md_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	sha1md_in_if  msg,
	sha1md_out_if digest,
	output int    fail_count,
	output int    words_due,
	output int    words_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam word_t H_INIT [WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam word_t ROUND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};
	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;
	localparam logic [2:0] FINAL_POS  = 3'd4;

	typedef struct packed {
		word_t      digest;
		logic [2:0] pos;
		logic       last;
	} digest_entry_t;

	word_t         chain_h [WORDS];
	word_t         sched_w [16];
	logic [5:0]    fill_bytes;
	logic [63:0]   bit_count;
	digest_entry_t digest_due_q [$];
	digest_entry_t head;

	task automatic sha1_compress();
		word_t a, b, c, d, e, f, w, k, tmp;
		int    t;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			t = r % 16;
			if (r >= 16) begin
				w = sched_w[(t + 13) % 16] ^ sched_w[(t + 8) % 16] ^ sched_w[(t + 2) % 16]
					^ sched_w[t];
				sched_w[t] = {w[30:0], w[31]};
			end
			w = sched_w[t];
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = ROUND_K[0];
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = ROUND_K[1];
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = ROUND_K[2];
			end else begin
				f = b ^ c ^ d;
				k = ROUND_K[3];
			end
			tmp = {a[26:0], a[31:27]} + f + e + k + w;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = tmp;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic sha1_absorb_byte(input logic [7:0] data);
		logic [3:0] idx;
		logic [1:0] lane;
		word_t      v;
		idx  = fill_bytes[5:2];
		lane = fill_bytes[1:0];
		v = word_t'(data) << ((3 - lane) * 8);
		if (lane == 2'd0)
			sched_w[idx] = v;
		else
			sched_w[idx] |= v;
		fill_bytes = fill_bytes + 6'd1;
		if (fill_bytes == 6'd0)
			sha1_compress();
	endtask

	task automatic sha1_take_item(input logic [7:0] data, input logic present, input logic eom);
		logic [63:0]   len_bits;
		digest_entry_t ent;
		if (present) begin
			sha1_absorb_byte(data);
			bit_count += 64'd8;
		end
		if (eom) begin
			len_bits = bit_count;
			sha1_absorb_byte(PAD_BYTE);
			while (fill_bytes != LEN_OFFSET)
				sha1_absorb_byte(8'h00);
			for (int i = 0; i < 8; i++)
				sha1_absorb_byte(len_bits[63 - 8 * i -: 8]);
			for (int i = 0; i < WORDS; i++) begin
				ent.digest = chain_h[i];
				ent.pos    = 3'(i);
				ent.last   = (3'(i) == FINAL_POS);
				digest_due_q = {digest_due_q, ent};
			end
			chain_h    = H_INIT;
			fill_bytes = '0;
			bit_count  = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_h    = H_INIT;
			sched_w    = '{default: '0};
			fill_bytes = '0;
			bit_count  = '0;
			digest_due_q.delete();
			fail_count = 0;
			words_due  = 0;
			words_seen = 0;
		end else begin
			// check outputs first: a digest leaving now belongs to an earlier message
			if (digest.valid && digest.ready) begin
				if (digest_due_q.size() == 0) begin
					$error("unexpected digest item: digest_word %h word_index %0d",
						digest.digest_word, digest.word_index);
					fail_count++;
				end else begin
					head = digest_due_q.pop_front();
					words_seen++;
					if (digest.digest_word !== head.digest) begin
						$error("digest_word: expected %h, actual %h", head.digest,
							digest.digest_word);
						fail_count++;
					end
					if (digest.word_index !== head.pos) begin
						$error("word_index: expected %0d, actual %0d", head.pos,
							digest.word_index);
						fail_count++;
					end
					if (digest.last_word !== head.last) begin
						$error("last_word: expected %0b, actual %0b", head.last,
							digest.last_word);
						fail_count++;
					end
				end
			end
			if (msg.valid && msg.ready)
				sha1_take_item(msg.message_byte, msg.byte_present, msg.end_of_message);
			words_due = digest_due_q.size();
		end
	end

endmodule

/* tb/sv/sha1_message_digest_tb.sv */
module sha1_message_digest_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS = 250;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	sha1md_in_if  msg_if ();
	sha1md_out_if dig_if ();

	int check_fails;
	int words_due;
	int words_seen;

	int idle_pct = 23;
	bit rx_hold_go = 1'b0;
	int items_sent = 0;
	int messages_sent = 0;
	int longest_msg = 0;

	sha1_message_digest i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (dig_if)
	);

	sha1_message_digest_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg_if),
		.digest     (dig_if),
		.fail_count (check_fails),
		.words_due  (words_due),
		.words_seen (words_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
		while ($urandom_range(99) < idle_pct) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid          <= 1'b1;
		msg_if.message_byte   <= data;
		msg_if.byte_present   <= present;
		msg_if.end_of_message <= eom;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		if (present || eom)
			items_sent++;
		if (eom)
			messages_sent++;
	endtask

	task automatic send_message(input int len, input bit empty_tail, input bit noise);
		for (int i = 0; i < len; i++) begin
			// sprinkle absent, non-final items that the block should skip
			if (noise && $urandom_range(99) < 6)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !empty_tail);
		end
		if (len == 0 || empty_tail)
			send_item(8'($urandom), 1'b0, 1'b1);
		if (len > longest_msg)
			longest_msg = len;
	endtask

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		dig_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				dig_if.ready <= 1'b0;
				hold_left--;
			end else begin
				dig_if.ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		int pick;
		int len;
		int msg_no;
		arst_n                = 1'b0;
		msg_if.valid          <= 1'b0;
		msg_if.message_byte   <= 8'h00;
		msg_if.byte_present   <= 1'b0;
		msg_if.end_of_message <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message
		send_item(8'h00, 1'b0, 1'b1);
		// "abc"
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// skipped item inside a message, then an empty final item
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
		// single-byte messages at the byte extremes, then a two-byte message
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7F, 1'b1, 1'b1);

		msg_no = 0;
		while (items_sent < RAND_ITEMS) begin
			// drop idling on both sides for a stretch of messages
			idle_pct = (msg_no >= 4 && msg_no < 8) ? 0 : 23;
			if (msg_no == 2)
				rx_hold_go = 1'b1;
			pick = $urandom_range(99);
			if (pick < 60)
				len = $urandom_range(10);
			else if (pick < 90)
				len = $urandom_range(66, 54);
			else
				len = $urandom_range(130, 118);
			// trim the last message to the item budget
			if (len > RAND_ITEMS - items_sent)
				len = RAND_ITEMS - items_sent;
			send_message(len, ($urandom_range(3) == 0), ($urandom_range(1) == 1));
			msg_no++;
		end
		msg_if.valid <= 1'b0;

		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d items in %0d messages, longest %0d bytes; %0d digest words checked",
			items_sent, messages_sent, longest_msg, words_seen);
		if (check_fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
